// ===== design/rfa_pkg.sv =====
// Package for rational_fraction_alu: item types, operation and status codes.
// No dependencies.
package rfa_pkg;
   localparam int WORD_BITS = 32;
   localparam int MAG_BITS  = 2 * WORD_BITS;

   localparam logic [2:0] OP_NORM = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_CMP  = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] a_numerator;
      logic signed [31:0] a_denominator;
      logic signed [31:0] b_numerator;
      logic signed [31:0] b_denominator;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_numerator;
      logic [30:0]        result_denominator;
      logic               less_flag;
      logic               equal_flag;
      logic [1:0]         status;
   } rsp_type;
endpackage

// ===== design/rational_fraction_alu.sv =====
// Top level of rational_fraction_alu: sequenced rational arithmetic with GCD reduction.
// Depends on rfa_pkg.
//
//  channel | ports                          | direction
//  req     | req_valid req_ready req_data   | in
//  rsp     | rsp_valid rsp_ready rsp_data   | out
//
// One item at a time. A shared 64-bit subtract/shift unit does all reduction:
// binary GCD (one step a cycle, at most about two steps per operand bit) and
// restoring division by the GCD (numerator in S_DIVN, then denominator in S_DIVD).
// Normalize reduces A only; add, sub, mul and div reduce A, B and the result,
// and compare reduces A and B. One shared 32x32 multiplier forms the cross
// products in S_MULA, S_MULB and S_MULC. Error items skip reduction and go
// from S_SPLIT to S_FIN. Reset returns the sequencer to idle; a stalled result holds.
module rational_fraction_alu (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rfa_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rfa_pkg::rsp_type rsp_data
);
   import rfa_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SPLIT = 4'd1;
   localparam logic [3:0] S_RA    = 4'd2;
   localparam logic [3:0] S_RB    = 4'd3;
   localparam logic [3:0] S_MULA  = 4'd4;
   localparam logic [3:0] S_MULB  = 4'd5;
   localparam logic [3:0] S_COMB  = 4'd6;
   localparam logic [3:0] S_GCD   = 4'd7;
   localparam logic [3:0] S_DIVN  = 4'd8;
   localparam logic [3:0] S_DIVD  = 4'd9;
   localparam logic [3:0] S_FIN   = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;
   localparam logic [3:0] S_MULC  = 4'd12;

   localparam logic [1:0] PH_A = 2'd0;
   localparam logic [1:0] PH_B = 2'd1;
   localparam logic [1:0] PH_R = 2'd2;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  op_ff, op_in;
   req_type     req_ff, req_in;
   logic        an_ff, an_in, bn_ff, bn_in, rn_ff, rn_in;
   logic [MAG_BITS-1:0] anm_ff, anm_in, adm_ff, adm_in, bnm_ff, bnm_in, bdm_ff, bdm_in;
   logic [MAG_BITS-1:0] num_ff, num_in, den_ff, den_in;
   logic [MAG_BITS-1:0] gx_ff, gx_in, gy_ff, gy_in, g_ff, g_in;
   logic [5:0]  sh_ff, sh_in;
   logic [MAG_BITS-1:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [MAG_BITS-1:0] p_ff, p_in, q_ff, q_in;
   logic [1:0]  st_ff, st_in;
   rsp_type     out_ff, out_in;

   logic [WORD_BITS-1:0] w_an, w_ad, w_bn, w_bd;
   logic [MAG_BITS-1:0]  div_src, rem_sh, rem_sub;
   logic                 rem_ge;
   logic [MAG_BITS-1:0]  gdiff;
   logic                 sb;
   logic [MAG_BITS-1:0]  half;
   logic [WORD_BITS-1:0] mul_x, mul_y;
   logic [MAG_BITS-1:0]  mul_p;

   function automatic logic [MAG_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0] t;
      t = v[WORD_BITS-1] ? (~v + 1'b1) : v;
      return {{(MAG_BITS-WORD_BITS){1'b0}}, t};
   endfunction

   assign w_an = req_ff.a_numerator[WORD_BITS-1:0];
   assign w_ad = req_ff.a_denominator[WORD_BITS-1:0];
   assign w_bn = req_ff.b_numerator[WORD_BITS-1:0];
   assign w_bd = req_ff.b_denominator[WORD_BITS-1:0];
   assign half = {{(MAG_BITS-1){1'b0}}, 1'b1} << (WORD_BITS - 1);

   assign div_src = (state_ff == S_DIVN) ? num_ff : den_ff;
   assign rem_sh  = {rem_ff[MAG_BITS-2:0], div_src[cnt_ff]};
   assign rem_ge  = rem_sh >= g_ff;
   assign rem_sub = rem_sh - g_ff;
   assign gdiff   = (gx_ff > gy_ff) ? gx_ff - gy_ff : gy_ff - gx_ff;
   assign sb = (op_ff == OP_SUB) ? (!bn_ff && bnm_ff != '0) : bn_ff;

   // reduced magnitudes fit one word, so one 32x32 product serves all three steps
   assign mul_x = (state_ff == S_MULA) ? anm_ff[WORD_BITS-1:0] : adm_ff[WORD_BITS-1:0];
   assign mul_y = (state_ff == S_MULA) ?
                  ((op_ff == OP_MUL) ? bnm_ff[WORD_BITS-1:0] : bdm_ff[WORD_BITS-1:0]) :
                  (state_ff == S_MULB && op_ff != OP_MUL) ? bnm_ff[WORD_BITS-1:0] :
                  bdm_ff[WORD_BITS-1:0];
   assign mul_p = {{WORD_BITS{1'b0}}, mul_x} * {{WORD_BITS{1'b0}}, mul_y};

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = out_ff;

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; op_in = op_ff; req_in = req_ff;
      an_in = an_ff; bn_in = bn_ff; rn_in = rn_ff;
      anm_in = anm_ff; adm_in = adm_ff; bnm_in = bnm_ff; bdm_in = bdm_ff;
      num_in = num_ff; den_in = den_ff; gx_in = gx_ff; gy_in = gy_ff; g_in = g_ff;
      sh_in = sh_ff; quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      p_in = p_ff; q_in = q_ff; st_in = st_ff; out_in = out_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               op_in  = (req_data.operation > OP_CMP) ? OP_NORM : req_data.operation;
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            anm_in = mag(w_an); adm_in = mag(w_ad);
            bnm_in = mag(w_bn); bdm_in = mag(w_bd);
            an_in = (w_an[WORD_BITS-1] != w_ad[WORD_BITS-1]) && w_an != '0;
            bn_in = (w_bn[WORD_BITS-1] != w_bd[WORD_BITS-1]) && w_bn != '0;
            st_in = ST_OK;
            if (w_ad == '0 || (op_ff != OP_NORM && w_bd == '0)) begin
               st_in = ST_ZERO_DEN;
               state_in = S_FIN;
            end else if (op_ff == OP_DIV && w_bn == '0) begin
               st_in = ST_DIV_ZERO;
               state_in = S_FIN;
            end else begin
               num_in = mag(w_an); den_in = mag(w_ad);
               phase_in = PH_A;
               gx_in = mag(w_an); gy_in = mag(w_ad); sh_in = '0;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            // binary GCD, one step per cycle
            if (gx_ff == '0 || gy_ff == '0) begin
               g_in = ((gx_ff | gy_ff) << sh_ff);
               if (g_in == '0) g_in = {{(MAG_BITS-1){1'b0}}, 1'b1};
               rem_in = '0; quo_in = '0; cnt_in = 6'(MAG_BITS - 1);
               state_in = S_DIVN;
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1; gy_in = gy_ff >> 1; sh_in = sh_ff + 6'd1;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else begin
               gx_in = (gx_ff < gy_ff) ? gx_ff : gy_ff;
               gy_in = gdiff;
            end
         end
         S_DIVN, S_DIVD: begin
            rem_in = rem_ge ? rem_sub : rem_sh;
            quo_in = {quo_ff[MAG_BITS-2:0], rem_ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               rem_in = '0; quo_in = '0; cnt_in = 6'(MAG_BITS - 1);
               if (state_ff == S_DIVN) begin
                  num_in = {quo_ff[MAG_BITS-2:0], rem_ge};
                  state_in = S_DIVD;
               end else begin
                  den_in = {quo_ff[MAG_BITS-2:0], rem_ge};
                  state_in = S_RA;
               end
            end
         end
         S_RA: begin
            unique case (phase_ff)
               PH_A: begin
                  anm_in = num_ff; adm_in = den_ff;
                  if (op_ff == OP_NORM) begin
                     rn_in = an_ff; phase_in = PH_R; state_in = S_RB;
                  end else begin
                     num_in = bnm_ff; den_in = bdm_ff;
                     gx_in = bnm_ff; gy_in = bdm_ff; sh_in = '0;
                     phase_in = PH_B; state_in = S_GCD;
                  end
               end
               PH_B: begin
                  bnm_in = num_ff; bdm_in = den_ff;
                  state_in = S_MULA;
               end
               default: begin
                  state_in = S_RB;
               end
            endcase
         end
         S_MULA: begin
            p_in = mul_p;
            state_in = S_MULB;
         end
         S_MULB: begin
            q_in = mul_p;
            state_in = S_MULC;
         end
         S_MULC: begin
            den_in = mul_p;
            state_in = S_COMB;
         end
         S_COMB: begin
            if (op_ff == OP_CMP) begin
               state_in = S_FIN;
            end else begin
               if (op_ff == OP_MUL || op_ff == OP_DIV) begin
                  rn_in = an_ff != bn_ff; num_in = p_ff; den_in = q_ff;
               end else if (an_ff == sb) begin
                  rn_in = an_ff; num_in = p_ff + q_ff;
               end else if (p_ff >= q_ff) begin
                  rn_in = an_ff; num_in = p_ff - q_ff;
               end else begin
                  rn_in = sb; num_in = q_ff - p_ff;
               end
               gx_in = num_in; gy_in = den_in; sh_in = '0;
               phase_in = PH_R; state_in = S_GCD;
            end
         end
         S_RB: begin
            if (num_ff == '0) begin
               rn_in = 1'b0; den_in = {{(MAG_BITS-1){1'b0}}, 1'b1};
            end
            state_in = S_FIN;
         end
         default: begin // S_FIN
            out_in = '0;
            out_in.status = st_ff;
            if (st_ff == ST_OK && op_ff == OP_CMP) begin
               out_in.less_flag = (an_ff != bn_ff) ? an_ff :
                                  an_ff ? (p_ff > q_ff) : (p_ff < q_ff);
               out_in.equal_flag = (an_ff == bn_ff) && p_ff == q_ff;
            end else if (st_ff == ST_OK) begin
               if (den_ff > half - 1'b1 ||
                   (rn_ff ? num_ff > half : num_ff > half - 1'b1)) begin
                  out_in.status = ST_OVERFLOW;
               end else begin
                  out_in.result_numerator = rn_ff ? 32'(-num_ff) : 32'(num_ff);
                  out_in.result_denominator = den_ff[30:0];
               end
            end
            if (state_ff == S_OUT) begin
               out_in = out_ff;
               if (rsp_ready) state_in = S_IDLE;
            end else begin
               state_in = S_OUT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      phase_ff <= phase_in; op_ff <= op_in; req_ff <= req_in;
      an_ff <= an_in; bn_ff <= bn_in; rn_ff <= rn_in;
      anm_ff <= anm_in; adm_ff <= adm_in; bnm_ff <= bnm_in; bdm_ff <= bdm_in;
      num_ff <= num_in; den_ff <= den_in; gx_ff <= gx_in; gy_ff <= gy_in;
      g_ff <= g_in; sh_ff <= sh_in; quo_ff <= quo_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; p_ff <= p_in; q_ff <= q_in; st_ff <= st_in;
      out_ff <= out_in;
   end
endmodule

// ===== design/rfa_checker.sv =====
// Port checker for rational_fraction_alu, bound to the top level.
// Depends on rfa_pkg.
module rfa_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rfa_pkg::rsp_type rsp_data
);
   import rfa_pkg::*;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accepting while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
      rsp_data.result_numerator == 0 && rsp_data.result_denominator == 0 &&
      !rsp_data.less_flag && !rsp_data.equal_flag) else $error("error result not zero");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.less_flag && rsp_data.equal_flag))
      else $error("less and equal both set");
endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (.*);
